FILE: hdl/mpwd_pkg.sv
// Shared constants and types for the morse pulse word decoder.
package mpwd_pkg;

    localparam int MAX_SYMBOLS   = 5;
    localparam int PREAMBLE_BITS = 7;
    localparam int TABLE_ENTRIES = 10;
    localparam int LOW_ENTRIES   = 6;
    localparam int HIGH_ENTRIES  = TABLE_ENTRIES - LOW_ENTRIES;

    localparam int SYM_W     = 2;
    localparam int WORD_W    = MAX_SYMBOLS * SYM_W;
    localparam int COUNT_W   = 3;
    localparam int INDEX_W   = 4;
    localparam int PRESS_W   = 16;
    localparam int RUN_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = LOW_ENTRIES * WORD_W;
    localparam int TLOW_W    = LOW_ENTRIES * WORD_W;
    localparam int THIGH_W   = HIGH_ENTRIES * WORD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_THRESH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_END = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_END     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_HIGH  = 3'd5;

    localparam logic [PREAMBLE_BITS-1:0] RST_PREAMBLE    = 7'd115;
    localparam logic [PRESS_W-1:0]       RST_DASH_THRESH = 16'd100;
    localparam logic [RUN_W-1:0]         RST_RELEASE_END = 12'd830;
    localparam logic [RUN_W-1:0]         RST_GAP_END     = 12'd3320;
    localparam logic [TLOW_W-1:0]        RST_TABLE_LOW   = 60'd727487354590549;
    localparam logic [THIGH_W-1:0]       RST_TABLE_HIGH  = 40'd0;

    typedef struct packed {
        logic [PREAMBLE_BITS-1:0] preamble_pattern;
        logic [PRESS_W-1:0]       dash_threshold;
        logic [RUN_W-1:0]         release_end;
        logic [RUN_W-1:0]         gap_end;
        logic [TLOW_W-1:0]        table_low;
        logic [THIGH_W-1:0]       table_high;
    } mpwd_cfg_t;

    typedef struct packed {
        logic [INDEX_W-1:0] word_index;
        logic               matched;
        logic [COUNT_W-1:0] symbol_count;
        logic [WORD_W-1:0]  symbols;
    } mpwd_result_t;

    localparam int RES_W      = $bits(mpwd_result_t);
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

endpackage

FILE: hdl/morse_pulse_word_decoder.sv
// Top level of the morse pulse word decoder.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  s_      | in        | s_tvalid/s_tready | s_tdata[0] light_active
//  m_      | out       | m_tvalid/m_tready | symbols, symbol_count, matched, word_index
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One sample beat per cycle; its state update and the table compare finish in that cycle.
//  A result beat enters the result buffer in the cycle after the sample that ends a message.
//  s_tready drops only while both result buffer entries are full.
//  Reset restores the configuration defaults and returns the sequencer to idle.
module morse_pulse_word_decoder
    import mpwd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [0] light_active
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [9:0] symbols, [12:10] symbol_count,
                                            // [13] matched, [17:14] word_index
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    mpwd_cfg_t    cfg;
    mpwd_result_t res;
    logic         res_valid;
    logic         beat;

    assign beat = s_tvalid && s_tready;

    mpwd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpwd_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .beat         (beat),
        .light_active (s_tdata[0]),
        .res_valid    (res_valid),
        .res          (res)
    );

    mpwd_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_data  (res),
        .space      (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: hdl/mpwd_cfg_regs.sv
// Configuration register file for the morse pulse word decoder.
module mpwd_cfg_regs
    import mpwd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output mpwd_cfg_t            cfg
);

    mpwd_cfg_t cfg_reg;
    mpwd_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PREAMBLE:    cfg_next.preamble_pattern = cfg_data[PREAMBLE_BITS-1:0];
                CFG_DASH_THRESH: cfg_next.dash_threshold   = cfg_data[PRESS_W-1:0];
                CFG_RELEASE_END: cfg_next.release_end      = cfg_data[RUN_W-1:0];
                CFG_GAP_END:     cfg_next.gap_end          = cfg_data[RUN_W-1:0];
                CFG_TABLE_LOW:   cfg_next.table_low        = cfg_data[TLOW_W-1:0];
                CFG_TABLE_HIGH:  cfg_next.table_high       = cfg_data[THIGH_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_pattern <= RST_PREAMBLE;
            cfg_reg.dash_threshold   <= RST_DASH_THRESH;
            cfg_reg.release_end      <= RST_RELEASE_END;
            cfg_reg.gap_end          <= RST_GAP_END;
            cfg_reg.table_low        <= RST_TABLE_LOW;
            cfg_reg.table_high       <= RST_TABLE_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/mpwd_matcher.sv
// Parallel compare of a symbol word against the pattern table, last hit wins.
module mpwd_matcher
    import mpwd_pkg::*;
(
    input  logic [WORD_W-1:0]  symbols,
    input  logic [TLOW_W-1:0]  table_low,
    input  logic [THIGH_W-1:0] table_high,
    output logic               matched,
    output logic [INDEX_W-1:0] word_index
);

    logic [TABLE_ENTRIES*WORD_W-1:0] entries;

    assign entries = {table_high, table_low};

    always_comb
    begin
        matched    = 1'b0;
        word_index = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if ((entries[i*WORD_W +: WORD_W] != '0) &&
                (entries[i*WORD_W +: WORD_W] == symbols))
            begin
                matched    = 1'b1;
                word_index = INDEX_W'(i);
            end
        end
    end

endmodule

FILE: hdl/mpwd_core.sv
// Frame, press and gap sequencer that builds the symbol word per sample.
module mpwd_core
    import mpwd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  mpwd_cfg_t    cfg,
    input  logic         beat,
    input  logic         light_active,
    output logic         res_valid,
    output mpwd_result_t res
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_FRAME   = 2'd1;
    localparam logic [1:0] PH_PRESSED = 2'd2;
    localparam logic [1:0] PH_GAP     = 2'd3;

    localparam int          TICK_W     = 4;
    localparam logic [TICK_W-1:0] SKIP_TICKS = TICK_W'(2);
    localparam logic [TICK_W-1:0] LAST_TICK  = TICK_W'(2 + PREAMBLE_BITS);
    localparam logic [SYM_W-1:0]  SYM_DOT    = 2'd1;
    localparam logic [SYM_W-1:0]  SYM_DASH   = 2'd2;

    logic [1:0]               phase_reg, phase_next;
    logic [TICK_W-1:0]        frame_tick_reg, frame_tick_next;
    logic [PREAMBLE_BITS-1:0] preamble_shift_reg, preamble_shift_next;
    logic [PRESS_W-1:0]       press_count_reg, press_count_next;
    logic [RUN_W-1:0]         release_run_reg, release_run_next;
    logic [RUN_W-1:0]         gap_count_reg, gap_count_next;
    logic [WORD_W-1:0]        symbol_store_reg, symbol_store_next;
    logic [COUNT_W-1:0]       symbols_seen_reg, symbols_seen_next;

    logic                     finish;
    logic [TICK_W-1:0]        tick_inc;
    logic [PREAMBLE_BITS-1:0] shift_val;
    logic [RUN_W-1:0]         run_inc;
    logic [SYM_W-1:0]         code;
    logic                     hit;
    logic [INDEX_W-1:0]       hit_index;
    logic [WORD_W-1:0]        word_done;
    logic [COUNT_W-1:0]       count_done;

    always_comb
    begin
        phase_next          = phase_reg;
        frame_tick_next     = frame_tick_reg;
        preamble_shift_next = preamble_shift_reg;
        press_count_next    = press_count_reg;
        release_run_next    = release_run_reg;
        gap_count_next      = gap_count_reg;
        symbol_store_next   = symbol_store_reg;
        symbols_seen_next   = symbols_seen_reg;
        finish              = 1'b0;
        tick_inc            = frame_tick_reg + 1'b1;
        shift_val           = (frame_tick_reg >= SKIP_TICKS) ?
                              {preamble_shift_reg[PREAMBLE_BITS-2:0], light_active} :
                              preamble_shift_reg;
        run_inc             = (release_run_reg == '1) ? release_run_reg :
                              release_run_reg + 1'b1;
        code                = (press_count_reg > cfg.dash_threshold) ? SYM_DASH : SYM_DOT;

        if (beat)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (light_active)
                    begin
                        phase_next          = PH_FRAME;
                        frame_tick_next     = '0;
                        preamble_shift_next = '0;
                        press_count_next    = '0;
                        release_run_next    = '0;
                        gap_count_next      = '0;
                        symbol_store_next   = '0;
                        symbols_seen_next   = '0;
                    end
                end
                PH_FRAME:
                begin
                    frame_tick_next     = tick_inc;
                    preamble_shift_next = shift_val;
                    if (tick_inc >= LAST_TICK)
                    begin
                        frame_tick_next     = '0;
                        preamble_shift_next = '0;
                        phase_next = (shift_val == cfg.preamble_pattern) ? PH_PRESSED : PH_IDLE;
                    end
                end
                PH_PRESSED:
                begin
                    if (light_active)
                    begin
                        if (press_count_reg != '1)
                        begin
                            press_count_next = press_count_reg + 1'b1;
                        end
                        release_run_next = '0;
                    end
                    else if (run_inc < cfg.release_end)
                    begin
                        release_run_next = run_inc;
                    end
                    else
                    begin
                        if (symbols_seen_reg < COUNT_W'(MAX_SYMBOLS))
                        begin
                            for (int i = 0; i < MAX_SYMBOLS; i++)
                            begin
                                if (symbols_seen_reg == COUNT_W'(i))
                                begin
                                    symbol_store_next[i*SYM_W +: SYM_W] =
                                        symbol_store_reg[i*SYM_W +: SYM_W] | code;
                                end
                            end
                            symbols_seen_next = symbols_seen_reg + 1'b1;
                        end
                        press_count_next = '0;
                        release_run_next = '0;
                        gap_count_next   = '0;
                        if (symbols_seen_next >= COUNT_W'(MAX_SYMBOLS))
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_GAP;
                        end
                    end
                end
                PH_GAP:
                begin
                    if (light_active)
                    begin
                        gap_count_next = '0;
                        phase_next     = PH_PRESSED;
                    end
                    else if (gap_count_reg >= cfg.gap_end)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        gap_count_next = gap_count_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        res_valid  = finish;
        word_done  = symbol_store_next;
        count_done = symbols_seen_next;

        if (finish)
        begin
            phase_next          = PH_IDLE;
            frame_tick_next     = '0;
            preamble_shift_next = '0;
            press_count_next    = '0;
            release_run_next    = '0;
            gap_count_next      = '0;
            symbol_store_next   = '0;
            symbols_seen_next   = '0;
        end
    end

    assign res = '{word_index: hit_index, matched: hit, symbol_count: count_done,
                   symbols: word_done};

    mpwd_matcher u_matcher
    (
        .symbols    (word_done),
        .table_low  (cfg.table_low),
        .table_high (cfg.table_high),
        .matched    (hit),
        .word_index (hit_index)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            frame_tick_reg     <= '0;
            preamble_shift_reg <= '0;
            press_count_reg    <= '0;
            release_run_reg    <= '0;
            gap_count_reg      <= '0;
            symbol_store_reg   <= '0;
            symbols_seen_reg   <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            frame_tick_reg     <= frame_tick_next;
            preamble_shift_reg <= preamble_shift_next;
            press_count_reg    <= press_count_next;
            release_run_reg    <= release_run_next;
            gap_count_reg      <= gap_count_next;
            symbol_store_reg   <= symbol_store_next;
            symbols_seen_reg   <= symbols_seen_next;
        end
    end

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        symbols_seen_reg < COUNT_W'(MAX_SYMBOLS))
        else $error("symbol count reached the message limit without finishing");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (symbols_seen_reg == '0) && (symbol_store_reg == '0))
        else $error("idle phase holds stale symbols");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (phase_reg == PH_IDLE))
        else $error("result beat not followed by idle phase");

    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.symbol_count != '0) && (res.symbols[SYM_W-1:0] != '0))
        else $error("result beat with no symbols");

endmodule

FILE: hdl/mpwd_out_buf.sv
// Two-entry result buffer that decouples the sample side from the result side.
module mpwd_out_buf
    import mpwd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  mpwd_result_t         push_data,
    output logic                 space,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic         head_valid_reg, head_valid_next;
    logic         tail_valid_reg, tail_valid_next;
    mpwd_result_t head_reg, head_next;
    mpwd_result_t tail_reg, tail_next;
    logic         pop;

    assign space    = !tail_valid_reg;
    assign m_tvalid = head_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, head_reg};
    assign pop      = head_valid_reg && m_tready;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        if (pop)
        begin
            if (tail_valid_reg)
            begin
                head_next       = tail_reg;
                tail_valid_next = push_valid;
                tail_next       = push_data;
            end
            else
            begin
                head_valid_next = push_valid;
                head_next       = push_data;
            end
        end
        else if (!head_valid_reg)
        begin
            head_valid_next = push_valid;
            head_next       = push_data;
        end
        else if (push_valid)
        begin
            tail_valid_next = 1'b1;
            tail_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    a_tail_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid_reg |-> head_valid_reg)
        else $error("tail entry held without a head entry");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !tail_valid_reg)
        else $error("result pushed into a full buffer");

endmodule
